// ----- design/hdes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdes_pkg: shared types and constants for Holt double exponential smoothing
// Widths, command and register codes, sequencer states and the saturation
// helper and gain clamp used by the smoothing datapath.
// ----------------------------------------------------------------------------
package hdes_pkg;

   // Datapath width that saturation clamps to (at most 32 bits).
   localparam int DATA_WIDTH = 32;
   localparam int SAT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

   // Fixed field widths.
   localparam int VAL_W    = 32;              // Q16.16 value
   localparam int GAIN_W   = 17;              // Q1.16 gain
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 2;
   localparam int FRAC_W   = 16;
   localparam int OP_W     = VAL_W + 1;       // sums of two values
   localparam int PROD_W   = GAIN_W + 1 + OP_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int RND_W    = ACC_W - FRAC_W;

   localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8192);
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32768);

   localparam longint SAT_MAX = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
   localparam longint SAT_MIN = -SAT_MAX - 64'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_FLUSH = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      REG_ALPHA = 2'd0,
      REG_BETA  = 2'd1,
      REG_SPARE2 = 2'd2,
      REG_SPARE3 = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_L_MUL1,
      ST_L_MUL2,
      ST_L_ACC,
      ST_L_RND,
      ST_T_MUL1,
      ST_T_MUL2,
      ST_T_ACC,
      ST_T_RND
   } seq_state_type;

   // Clamp a wide signed value to the SAT_BITS range.
   function automatic logic signed [VAL_W-1:0] sat_value(
      input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = RND_W'(SAT_MAX);
      lo = RND_W'(SAT_MIN);
      if (v > hi) begin
         return VAL_W'(hi);
      end else if (v < lo) begin
         return VAL_W'(lo);
      end
      return VAL_W'(v);
   endfunction

   // Gains above one act as one.
   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

endpackage

// ----- design/holt_double_exp_smoothing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// holt_double_exp_smoothing: level and trend smoothing of a Q16.16 stream
// Iterative datapath: one shared 18x33 multiplier and one accumulator run
// under a small sequencer to form the level and trend updates.
// ----------------------------------------------------------------------------
// Usage:
//  - Request words (req_*) carry a command, a sample and a sample-valid flag.
//    A word is taken on a rising edge with req_valid high and req_stall low.
//  - Add with a valid sample updates the state; the first sample after reset
//    or a clear command only loads level and trend, every later one has the
//    sequencer walk the shared multiplier through four products. Add with
//    an invalid sample, clear and the unused command leave the sequencer idle.
//  - Flush produces one response word (rsp_*) in the cycle after it is taken.
//    The response sits in an output register; while it waits under rsp_stall
//    the block still takes adds and clears, and only a second flush stalls.
//  - Gains are written on the csr_* channel, index 0 alpha and 1 beta; the
//    channel is always ready and clamps gains above one to one. Writes are
//    expected only while the block is idle.
//  - Synchronous reset clears level, trend, sample count and pending response
//    and restores both gains to 8192 (0.125).
// ----------------------------------------------------------------------------
module holt_double_exp_smoothing
   import hdes_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [VAL_W-1:0]  req_sample,
   input  logic                     req_sample_valid,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [VAL_W-1:0]  rsp_smoothed_level,
   output logic                     rsp_empty_res,
   // configuration channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [GAIN_W-1:0]        csr_wdata
);

   // Control state.
   seq_state_type             state_ff, state_in;
   logic [1:0]                seen_count_ff, seen_count_in;
   logic signed [VAL_W-1:0]   level_ff, level_in;
   logic signed [VAL_W-1:0]   trend_ff, trend_in;
   logic [GAIN_W-1:0]         alpha_ff, alpha_in;
   logic [GAIN_W-1:0]         beta_ff, beta_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [VAL_W-1:0]   x_ff, x_in;
   logic signed [VAL_W-1:0]   old_level_ff, old_level_in;
   logic signed [OP_W-1:0]    op_ff, op_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [VAL_W-1:0]   rsp_level_ff, rsp_level_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   // Shared multiplier operands and rounding.
   logic [GAIN_W-1:0]         mul_gain;
   logic signed [OP_W-1:0]    mul_val;
   logic signed [ACC_W-1:0]   acc_bias;
   logic signed [RND_W-1:0]   acc_rnd;
   logic signed [OP_W-1:0]    first_diff;
   logic                      req_take;
   cmd_type                   req_cmd;

   assign req_cmd   = cmd_type'(req_command);
   // A flush needs room in the output register; everything else only needs
   // the sequencer to be idle.
   assign req_stall = (state_ff != ST_IDLE) ||
                      ((req_cmd == CMD_FLUSH) && rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_level = rsp_level_ff;
   assign rsp_empty_res      = rsp_empty_ff;

   // Round half up to Q16.16: add half an LSB, then floor by the shift.
   assign acc_bias   = acc_ff + HALF_LSB;
   assign acc_rnd    = $signed(acc_bias[ACC_W-1:FRAC_W]);
   assign first_diff = OP_W'(x_ff) - OP_W'(trend_ff);

   // The single multiplier; its product is always registered.
   assign prod_in = $signed({1'b0, mul_gain}) * mul_val;

   always_comb begin
      state_in      = state_ff;
      seen_count_in = seen_count_ff;
      level_in      = level_ff;
      trend_in      = trend_ff;
      alpha_in      = alpha_ff;
      beta_in       = beta_ff;
      x_in          = x_ff;
      old_level_in  = old_level_ff;
      op_in         = op_ff;
      acc_in        = acc_ff;
      mul_gain      = '0;
      mul_val       = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_level_in  = rsp_level_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_ALPHA: alpha_in = clamp_gain(csr_wdata);
            REG_BETA:  beta_in  = clamp_gain(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_cmd)
                  CMD_ADD: begin
                     if (req_sample_valid) begin
                        x_in     = sat_value(RND_W'(req_sample));
                        state_in = ST_LOAD;
                     end
                  end
                  CMD_FLUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_empty_in = (seen_count_ff == 2'd0);
                     rsp_level_in = (seen_count_ff == 2'd0) ? '0 : level_ff;
                  end
                  CMD_CLEAR: begin
                     level_in      = '0;
                     trend_in      = '0;
                     seen_count_in = 2'd0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            if (seen_count_ff == 2'd0) begin
               level_in      = x_ff;
               trend_in      = x_ff;
               seen_count_in = 2'd1;
               state_in      = ST_IDLE;
            end else begin
               if (seen_count_ff == 2'd1) begin
                  trend_in      = sat_value(RND_W'(first_diff));
                  level_in      = x_ff;
                  seen_count_in = 2'd2;
               end
               state_in = ST_L_MUL1;
            end
         end
         ST_L_MUL1: begin
            mul_gain     = alpha_ff;
            mul_val      = OP_W'(x_ff);
            op_in        = OP_W'(level_ff) + OP_W'(trend_ff);
            old_level_in = level_ff;
            state_in     = ST_L_MUL2;
         end
         ST_L_MUL2: begin
            mul_gain = GAIN_ONE - alpha_ff;
            mul_val  = op_ff;
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_L_ACC;
         end
         ST_L_ACC: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_L_RND;
         end
         ST_L_RND: begin
            level_in = sat_value(acc_rnd);
            state_in = ST_T_MUL1;
         end
         ST_T_MUL1: begin
            mul_gain = GAIN_ONE - beta_ff;
            mul_val  = OP_W'(trend_ff);
            op_in    = OP_W'(level_ff) - OP_W'(old_level_ff);
            state_in = ST_T_MUL2;
         end
         ST_T_MUL2: begin
            mul_gain = beta_ff;
            mul_val  = op_ff;
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_T_ACC;
         end
         ST_T_ACC: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_T_RND;
         end
         ST_T_RND: begin
            trend_in = sat_value(acc_rnd);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seen_count_ff <= 2'd0;
         level_ff      <= '0;
         trend_ff      <= '0;
         alpha_ff      <= GAIN_RESET;
         beta_ff       <= GAIN_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seen_count_ff <= seen_count_in;
         level_ff      <= level_in;
         trend_ff      <= trend_in;
         alpha_ff      <= alpha_in;
         beta_ff       <= beta_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      old_level_ff <= old_level_in;
      op_ff        <= op_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_level_ff <= rsp_level_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // A taken flush always shows up as a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_cmd == CMD_FLUSH)) |=> rsp_valid)
      else $error("flush did not produce a response");

   // The sample count stops at two.
   assert property (@(posedge clock) disable iff (reset)
      seen_count_ff != 2'd3)
      else $error("sample count ran past two");

   // An empty response carries a zero level.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_smoothed_level == '0))
      else $error("empty response with nonzero level");

   // The trend step always closes the update and frees the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T_RND) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle");

endmodule
